// File: design/fba_pkg.sv
// Shared codes, control/status bundles and helpers for the frame bitmap allocator.
// No dependencies; used by fba_ctrl, fba_datapath and frame_bitmap_allocator.
package fba_pkg;

    // Operation codes on the command port
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_APPLIED   = 2'd0;
    localparam logic [1:0] ST_ALLOCATED = 2'd1;
    localparam logic [1:0] ST_NONE_FREE = 2'd2;

    localparam int WORD_BITS = 16;
    localparam int FIELD_W   = 11;
    localparam int FRAME_W   = 10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;   // latch the item, rewind the word pointer
        logic       step;   // read the word at the pointer, advance it
        logic       fill;   // write the range mask at the pointer
        logic       rmw;    // write read word OR range mask back
        logic       take;   // clear the lowest free bit of the read word
        logic       emit;   // present a result beat
        logic [1:0] code;   // status of that beat
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic addr_last;    // pointer sits on the last word
        logic rd_last;      // read word is the last word
        logic rd_live;      // read register holds a word of this item
        logic rd_hit;       // read word has a free frame
    } t_dp_stat;

    // Position of the lowest-numbered free frame in a word (frame j at bit 15-j)
    function automatic logic [3:0] lowest_free(input logic [WORD_BITS-1:0] word);
        logic [3:0] idx;
        idx = 4'd0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (word[WORD_BITS-1-j]) begin
                idx = 4'(j);
            end
        end
        return idx;
    endfunction

endpackage

// File: design/fba_ctrl.sv
// Controller state machine of the frame bitmap allocator.
// Depends on fba_pkg; drives fba_datapath through t_dp_cmd and reads t_dp_stat.
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_operation,
    input  fba_pkg::t_dp_stat i_stat,
    output fba_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import fba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_FILL     = 5'b00010,
        S_ADD      = 5'b00100,
        S_ADD_TAIL = 5'b01000,
        S_SCAN     = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.code = ST_APPLIED;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_operation)
                        OP_SET:   n_state = S_FILL;
                        OP_ADD:   n_state = S_ADD;
                        OP_ALLOC: n_state = S_SCAN;
                        default:  o_cmd.emit = 1'b1;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                o_cmd.step = 1'b1;
                if (i_stat.addr_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ADD: begin
                o_cmd.step = 1'b1;
                o_cmd.rmw  = i_stat.rd_live;
                if (i_stat.addr_last) begin
                    n_state = S_ADD_TAIL;
                end
            end
            S_ADD_TAIL: begin
                o_cmd.rmw  = 1'b1;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.rd_live && i_stat.rd_hit) begin
                    o_cmd.take = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_ALLOCATED;
                    n_state    = S_IDLE;
                end else if (i_stat.rd_live && i_stat.rd_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_NONE_FREE;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: design/fba_datapath.sv
// Datapath of the frame bitmap allocator: bitmap memory, word pointer, range masks,
// free-frame encoder and result registers. Depends on fba_pkg.
module fba_datapath #(
    parameter int NUM_FRAMES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fba_pkg::FIELD_W-1:0]  i_range_start,
    input  logic [fba_pkg::FIELD_W-1:0]  i_range_end,
    input  fba_pkg::t_dp_cmd             i_cmd,
    output fba_pkg::t_dp_stat            o_stat,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [fba_pkg::FRAME_W-1:0]  o_frame_number
);
    import fba_pkg::*;

    localparam int WORDS     = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW        = FIELD_W - 4;
    localparam int CW        = (AW > SW) ? AW : SW;
    localparam int FRW       = (AW + 4 > FRAME_W) ? AW + 4 : FRAME_W;
    localparam int TAIL_BITS = NUM_FRAMES % WORD_BITS;
    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        (TAIL_BITS == 0) ? ALL_ONES : ~(ALL_ONES >> TAIL_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     r_valid;
    logic [FIELD_W-1:0]   r_start, r_end;
    logic [AW-1:0]        r_addr, r_rd_addr;
    logic [WORD_BITS-1:0] r_rd_raw;
    logic                 r_rd_wv, r_rd_live;
    logic                 r_done;
    logic [1:0]           r_status;
    logic [FRAME_W-1:0]   r_frame;

    logic [WORD_BITS-1:0] rd_word, range_mask, lo_mask, hi_mask, lim_mask;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        mask_addr, wr_addr;
    logic                 wr_en;
    logic [CW-1:0]        w_cmp, ws_cmp, we_cmp;
    logic [3:0]           free_pos;
    logic [FRW-1:0]       frame_full;

    // Word from the read register; a never-written word reads as no frame free
    assign rd_word  = r_rd_wv ? r_rd_raw : '0;
    assign free_pos = lowest_free(rd_word);

    // Range mask for one word: frames start..end-1 that lie below NUM_FRAMES
    assign mask_addr = i_cmd.fill ? r_addr : r_rd_addr;
    assign w_cmp     = CW'(mask_addr);
    assign ws_cmp    = CW'(r_start[FIELD_W-1:4]);
    assign we_cmp    = CW'(r_end[FIELD_W-1:4]);

    always_comb begin
        if (w_cmp > ws_cmp) begin
            lo_mask = ALL_ONES;
        end else if (w_cmp == ws_cmp) begin
            lo_mask = ALL_ONES >> r_start[3:0];
        end else begin
            lo_mask = '0;
        end
        if (w_cmp < we_cmp) begin
            hi_mask = ALL_ONES;
        end else if (w_cmp == we_cmp) begin
            hi_mask = ~(ALL_ONES >> r_end[3:0]);
        end else begin
            hi_mask = '0;
        end
        lim_mask   = (mask_addr == LAST_ADDR) ? TAIL_MASK : ALL_ONES;
        range_mask = lo_mask & hi_mask & lim_mask;
    end

    // Select the write beat: range fill, merge or frame take
    always_comb begin
        wr_en   = i_cmd.fill | i_cmd.rmw | i_cmd.take;
        wr_addr = i_cmd.fill ? r_addr : r_rd_addr;
        if (i_cmd.fill) begin
            wr_data = range_mask;
        end else if (i_cmd.rmw) begin
            wr_data = rd_word | range_mask;
        end else begin
            wr_data = rd_word & ~(16'h8000 >> free_pos);
        end
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.step) begin
            r_rd_raw <= mem[r_addr];
        end
    end

    // Written flags per word; reset marks the whole bitmap empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Latch the item's range
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_range_start;
            r_end   <= i_range_end;
        end
    end

    // Word pointer and read tracking; hold the pointer on the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_addr <= '0;
            r_rd_wv   <= 1'b0;
            r_rd_live <= 1'b0;
        end else if (i_cmd.load) begin
            r_addr    <= '0;
            r_rd_live <= 1'b0;
        end else if (i_cmd.step) begin
            r_rd_addr <= r_addr;
            r_rd_wv   <= r_valid[r_addr];
            r_rd_live <= 1'b1;
            if (r_addr != LAST_ADDR) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    assign o_stat.addr_last = (r_addr == LAST_ADDR);
    assign o_stat.rd_last   = (r_rd_addr == LAST_ADDR);
    assign o_stat.rd_live   = r_rd_live;
    assign o_stat.rd_hit    = (rd_word != '0);

    // Result beat registers
    assign frame_full = FRW'({r_rd_addr, free_pos});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.code;
            r_frame  <= i_cmd.take ? frame_full[FRAME_W-1:0] : '0;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_frame_number = r_frame;

endmodule

// File: design/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: controller plus datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  command  | start / busy        | i_operation, i_range_start, i_range_end
//  result   | o_done (one cycle)  | o_status, o_frame_number
//
// One command at a time; busy covers the scan of the bitmap memory, one word per
// cycle (WORDS = ceil(NUM_FRAMES/16)). Set and add walk every word; allocate stops
// at the first word with a free frame, or at the last word; the unused code does
// not raise busy. The result beat sits in the first cycle with busy low after the
// command (the cycle after acceptance for the unused code).
// Synchronous active-low reset empties the bitmap at once. The receiver cannot
// stall: o_done is high for exactly one cycle per command.
module frame_bitmap_allocator #(
    parameter int NUM_FRAMES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic [fba_pkg::FIELD_W-1:0]  i_range_start,
    input  logic [fba_pkg::FIELD_W-1:0]  i_range_end,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [fba_pkg::FRAME_W-1:0]  o_frame_number
);
    import fba_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .busy        (busy)
    );

    fba_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_frame_number (o_frame_number)
    );

endmodule

// File: sim/frame_bitmap_allocator_tb.sv
// Self-checking testbench for frame_bitmap_allocator: drives set, add, allocate
// and unused commands, predicts every result beat from a local copy of the bitmap.
// Depends on fba_pkg and the frame_bitmap_allocator RTL.
`timescale 1ns / 100ps

module frame_bitmap_allocator_tb;

    import fba_pkg::*;

    localparam int          NUM_FRAMES    = 1024;
    localparam int          MAP_WORDS     = (NUM_FRAMES + 15) / 16;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          SETTLE_CYCLES = 2 * MAP_WORDS + 8;
    localparam int          PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
    } t_alloc_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic [FIELD_W-1:0] i_range_start;
    logic [FIELD_W-1:0] i_range_end;
    logic               o_done;
    logic [1:0]         o_status;
    logic [FRAME_W-1:0] o_frame_number;

    // Local copy of the bitmap: frame i sits in word i/16 at bit 15 - i%16
    logic [WORD_BITS-1:0] free_map [MAP_WORDS];
    t_alloc_result        pending_results [$];
    int                   error_count = 0;
    int                   idle_pct    = 0;

    frame_bitmap_allocator #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_frame_number (o_frame_number)
    );

    always #5 i_clk = ~i_clk;

    // Count a mismatch; stop printing once the log gets long
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Apply one accepted command to the local bitmap and queue its result
    task automatic predict_command(input logic [1:0] op, input logic [FIELD_W-1:0] first,
                                   input logic [FIELD_W-1:0] stop);
        int unsigned   f;
        t_alloc_result res;
        res.status = ST_APPLIED;
        res.frame  = '0;
        case (op)
            OP_SET, OP_ADD: begin
                if (op == OP_SET) begin
                    foreach (free_map[w]) free_map[w] = '0;
                end
                for (f = first; f < stop && f < NUM_FRAMES; f++) begin
                    free_map[f / 16][15 - (f % 16)] = 1'b1;
                end
            end
            OP_ALLOC: begin
                res.status = ST_NONE_FREE;
                for (f = 0; f < NUM_FRAMES; f++) begin
                    if (free_map[f / 16][15 - (f % 16)]) begin
                        free_map[f / 16][15 - (f % 16)] = 1'b0;
                        res.status = ST_ALLOCATED;
                        res.frame  = f[FRAME_W-1:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        pending_results.push_back(res);
    endtask

    // Present one command beat, idling first at random, and hold it until accepted
    task automatic send_command(input logic [1:0] op, input logic [FIELD_W-1:0] first,
                                input logic [FIELD_W-1:0] stop);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_range_start <= first;
        i_range_end   <= stop;
        do @(posedge i_clk); while (busy);
        predict_command(op, first, stop);
    endtask

    // Compare every result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected result beat status=%0d frame=%0d",
                                       o_status, o_frame_number));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    report_error($sformatf("status %0d, expected %0d",
                                           o_status, exp_res.status));
                end
                if (o_frame_number !== exp_res.frame) begin
                    report_error($sformatf("frame_number %0d, expected %0d",
                                           o_frame_number, exp_res.frame));
                end
            end
        end
    end

    // An empty bitmap after reset must refuse allocation
    task automatic test_empty_after_reset();
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ALLOC, 11'h7FF, 11'h7FF);
    endtask

    // Full range, last frame only, empty and reversed ranges, ranges past the end
    task automatic test_range_edges();
        send_command(OP_SET, 11'd0, 11'd1024);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_SET, 11'd1023, 11'd1024);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ADD, 11'd0, 11'd16);
        send_command(OP_SET, 11'd100, 11'd50);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ADD, 11'd5, 11'd5);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_SET, 11'd1000, 11'd2047);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_SET, 11'd1500, 11'd2000);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_SET, 11'h7FF, 11'd0);
    endtask

    // Allocation picks the lowest free frame across word boundaries
    task automatic test_alloc_order();
        send_command(OP_ADD, 11'd16, 11'd32);
        send_command(OP_ADD, 11'd0, 11'd1);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ALLOC, '0, '0);
        send_command(OP_ADD, 11'd7, 11'd8);
    endtask

    // The unused code answers with an applied status and leaves the bitmap alone
    task automatic test_unused_code();
        send_command(OP_UNUSED, 11'd0, 11'd1024);
        send_command(OP_UNUSED, 11'h7FF, 11'h2AA);
        send_command(OP_ALLOC, '0, '0);
    endtask

    // Bursts of set/add followed by allocations, with some noise mixed in
    task automatic test_random_traffic(input int gap_pct, input int num_items);
        int                 sent;
        int                 allocs;
        logic [1:0]         op;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] stop;
        idle_pct = gap_pct;
        sent     = 0;
        while (sent < num_items) begin
            op    = ($urandom_range(3) == 0) ? OP_SET : OP_ADD;
            first = FIELD_W'($urandom_range(1024));
            case ($urandom_range(11))
                0:       stop = FIELD_W'($urandom_range(1024));
                1:       stop = first;
                2: begin
                    first = FIELD_W'($urandom_range(2047));
                    stop  = FIELD_W'($urandom_range(2047));
                end
                3: begin
                    first = FIELD_W'($urandom_range(64));
                    stop  = 11'd1024;
                end
                default: stop = first + FIELD_W'($urandom_range(1, 48));
            endcase
            send_command(op, first, stop);
            sent++;
            allocs = $urandom_range(1, 24);
            repeat (allocs) begin
                if ($urandom_range(39) == 0) begin
                    send_command(OP_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom));
                end else begin
                    send_command(OP_ALLOC, FIELD_W'($urandom), FIELD_W'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial begin
        start         <= 1'b0;
        i_rst_n       <= 1'b0;
        i_operation   <= OP_SET;
        i_range_start <= '0;
        i_range_end   <= '0;
        foreach (free_map[w]) free_map[w] = '0;

        // Hold reset, then release it on a falling edge
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_after_reset();
        test_range_edges();
        test_alloc_order();
        test_unused_code();
        test_random_traffic(0, 375);
        test_random_traffic(45, 375);
        test_random_traffic(0, 375);
        test_random_traffic(33, 375);

        // Drop start, drain outstanding results, then watch for stray beats
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
